// ===== hdl/tpq_pkg.sv =====
// Shared types and constants for the touch press qualifier.
package tpq_pkg;

	localparam logic [11:0] RawMin     = 12'd220;
	localparam logic [11:0] RawMax     = 12'd3900;
	localparam logic [10:0] SizeMax    = 11'd1024;
	// (v - 220) * (size - 1) / 3680: 3680 = 32 * 115, the /115 by reciprocal
	localparam int unsigned PreShift   = 5;
	localparam logic [17:0] RecipMul   = 18'd145889;
	localparam int unsigned RecipShift = 24;

	typedef enum logic [3:0] {
		REG_SCREEN_WIDTH  = 4'd0,
		REG_SCREEN_HEIGHT = 4'd1,
		REG_BUTTON_LEFT   = 4'd2,
		REG_BUTTON_TOP    = 4'd3,
		REG_BUTTON_WIDTH  = 4'd4,
		REG_BUTTON_HEIGHT = 4'd5,
		REG_COOLDOWN_MS   = 4'd6,
		REG_PRESSURE_MIN  = 4'd7
	} reg_index_t;

	typedef struct packed {
		logic [10:0]        screen_width;
		logic [10:0]        screen_height;
		logic signed [10:0] button_left;
		logic signed [10:0] button_top;
		logic [9:0]         button_width;
		logic [9:0]         button_height;
		logic [15:0]        cooldown_ms;
		logic [12:0]        pressure_min;
	} cfg_t;

	typedef struct packed {
		logic        pen_down;
		logic [11:0] pressure_one;
		logic [11:0] pressure_two;
		logic [11:0] x_first;
		logic [11:0] x_second;
		logic [11:0] x_third;
		logic [11:0] y_first;
		logic [11:0] y_second;
		logic [11:0] y_third;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic        pressed;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [9:0]  screen_x;
		logic [9:0]  screen_y;
		logic        button_hit;
		logic [31:0] now_ms;
	} mid_item_t;

	typedef struct packed {
		logic        pressed;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [9:0]  screen_x;
		logic [9:0]  screen_y;
		logic        button_hit;
		logic        toggle;
	} out_item_t;

endpackage

// ===== hdl/tpq_front.sv =====
// Front pipeline: pressure test, medians, scaling and button hit test.
module tpq_front import tpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      mid_push,
	output mid_item_t mid_item,
	input  logic      mid_full
);

	function automatic logic [11:0] med3(input logic [11:0] a, input logic [11:0] b,
			input logic [11:0] c);
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	function automatic logic [11:0] clamp_off(input logic [11:0] v);
		logic [11:0] c;
		c = v;
		if (v < RawMin) begin
			c = RawMin;
		end else if (v > RawMax) begin
			c = RawMax;
		end
		return c - RawMin;
	endfunction

	// effective size minus one; zero taken as 1, above 1024 as 1024
	function automatic logic [9:0] size_m1(input logic [10:0] s);
		logic [10:0] d;
		if (s == 11'd0) begin
			d = 11'd0;
		end else if (s > SizeMax) begin
			d = SizeMax - 11'd1;
		end else begin
			d = s - 11'd1;
		end
		return d[9:0];
	endfunction

	function automatic logic in_btn(input logic signed [12:0] x, input logic signed [12:0] y,
			input cfg_t c);
		logic signed [12:0] l;
		logic signed [12:0] t;
		logic signed [12:0] r;
		logic signed [12:0] b;
		l = $signed({{2{c.button_left[10]}}, c.button_left});
		t = $signed({{2{c.button_top[10]}}, c.button_top});
		r = l + $signed({3'b000, c.button_width});
		b = t + $signed({3'b000, c.button_height});
		return (x >= l) && (x < r) && (y >= t) && (y < b);
	endfunction

	logic        adv;
	logic        acc;
	logic [9:0]  wm1;
	logic [9:0]  hm1;
	logic [12:0] psum;
	logic        v_s1, v_s2, v_s3, v_s4;

	logic        pressed_s1, pressed_s2, pressed_s3;
	logic [11:0] rx_s1, rx_s2, rx_s3;
	logic [11:0] ry_s1, ry_s2, ry_s3;
	logic [31:0] now_s1, now_s2, now_s3;
	logic [11:0] offx_s1, offy_s1;
	logic [21:0] prodx_s2, prody_s2;
	logic [34:0] qx_s3, qy_s3;
	mid_item_t   item_s4;

	logic [9:0]         sx_c, sy_c;
	logic signed [12:0] sxs, sys, wm1s, hm1s;
	logic               hit_c;

	assign adv  = !v_s4 || !mid_full;
	assign full = !adv;
	assign acc  = push && adv;
	assign wm1  = size_m1(cfg.screen_width);
	assign hm1  = size_m1(cfg.screen_height);
	// z1 + (4095 - z2)
	assign psum = {1'b0, item.pressure_one} + {1'b0, ~item.pressure_two};

	assign sx_c = pressed_s3 ? qx_s3[RecipShift+9:RecipShift] : 10'd0;
	assign sy_c = pressed_s3 ? qy_s3[RecipShift+9:RecipShift] : 10'd0;
	assign sxs  = $signed({3'b000, sx_c});
	assign sys  = $signed({3'b000, sy_c});
	assign wm1s = $signed({3'b000, wm1});
	assign hm1s = $signed({3'b000, hm1});
	// four screen rotations
	assign hit_c = pressed_s3 && (in_btn(sxs, sys, cfg) || in_btn(wm1s - sys, sxs, cfg) ||
		in_btn(wm1s - sxs, hm1s - sys, cfg) || in_btn(sys, hm1s - sxs, cfg));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pressed_s1 <= item.pen_down && (psum >= cfg.pressure_min);
			rx_s1      <= med3(item.x_first, item.x_second, item.x_third);
			ry_s1      <= med3(item.y_first, item.y_second, item.y_third);
			offx_s1    <= clamp_off(med3(item.x_first, item.x_second, item.x_third));
			offy_s1    <= clamp_off(med3(item.y_first, item.y_second, item.y_third));
			now_s1     <= item.now_ms;

			pressed_s2 <= pressed_s1;
			rx_s2      <= pressed_s1 ? rx_s1 : 12'd0;
			ry_s2      <= pressed_s1 ? ry_s1 : 12'd0;
			prodx_s2   <= 22'(offx_s1) * 22'(wm1);
			prody_s2   <= 22'(offy_s1) * 22'(hm1);
			now_s2     <= now_s1;

			pressed_s3 <= pressed_s2;
			rx_s3      <= rx_s2;
			ry_s3      <= ry_s2;
			qx_s3      <= 35'(prodx_s2[21:PreShift]) * 35'(RecipMul);
			qy_s3      <= 35'(prody_s2[21:PreShift]) * 35'(RecipMul);
			now_s3     <= now_s2;

			item_s4.pressed    <= pressed_s3;
			item_s4.raw_x      <= rx_s3;
			item_s4.raw_y      <= ry_s3;
			item_s4.screen_x   <= sx_c;
			item_s4.screen_y   <= sy_c;
			item_s4.button_hit <= hit_c;
			item_s4.now_ms     <= now_s3;
		end
	end

	assign mid_push = v_s4 && !mid_full;
	assign mid_item = item_s4;

endmodule

// ===== hdl/tpq_queue.sv =====
// Small register queue between the front and back parts.
module tpq_queue #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] data_in,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] data_out,
	output logic             empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

endmodule

// ===== hdl/tpq_back.sv =====
// Back part: press edge and cooldown tracking, result register.
module tpq_back import tpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      mid_empty,
	input  mid_item_t mid_item,
	output logic      mid_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic        was_pressed_q;
	logic [31:0] last_toggle_q;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        take;
	logic [31:0] elapsed;
	logic        fire;

	assign take    = !mid_empty && (!out_valid_q || pop);
	assign mid_pop = take;
	// wrapping difference
	assign elapsed = mid_item.now_ms - last_toggle_q;
	assign fire    = mid_item.pressed && !was_pressed_q && mid_item.button_hit &&
		(elapsed > {16'd0, cfg.cooldown_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			last_toggle_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				was_pressed_q <= mid_item.pressed;
				if (fire) begin
					last_toggle_q <= mid_item.now_ms;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.pressed    <= mid_item.pressed;
			out_q.raw_x      <= mid_item.raw_x;
			out_q.raw_y      <= mid_item.raw_y;
			out_q.screen_x   <= mid_item.screen_x;
			out_q.screen_y   <= mid_item.screen_y;
			out_q.button_hit <= mid_item.button_hit;
			out_q.toggle     <= fire;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== hdl/touch_press_qualifier.sv =====
// Top level: config registers, front pipeline, queue and back part.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  input    | push / full            | item   (in_item_t)
//  result   | empty / pop            | result (out_item_t)
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item is accepted per cycle while full is low; on its way to the result it passes
// the four front stages (median, scale multiply, reciprocal multiply, hit test),
// the queue and the result register.
// Reset clears the config to its defaults, the press and toggle state and the queue.
// A stalled result only stops the front once QueueDepth items wait in the queue.
module touch_press_qualifier import tpq_pkg::*; #(
	parameter int unsigned QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t      cfg_q;
	logic      mid_push;
	logic      mid_full;
	logic      mid_pop;
	logic      mid_empty;
	mid_item_t mid_in;
	mid_item_t mid_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= 11'd480;
			cfg_q.screen_height <= 11'd320;
			cfg_q.button_left   <= 11'sd194;
			cfg_q.button_top    <= 11'sd18;
			cfg_q.button_width  <= 10'd136;
			cfg_q.button_height <= 10'd28;
			cfg_q.cooldown_ms   <= 16'd600;
			cfg_q.pressure_min  <= 13'd150;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[10:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[10:0];
				REG_BUTTON_LEFT:   cfg_q.button_left   <= $signed(cfg_data[10:0]);
				REG_BUTTON_TOP:    cfg_q.button_top    <= $signed(cfg_data[10:0]);
				REG_BUTTON_WIDTH:  cfg_q.button_width  <= cfg_data[9:0];
				REG_BUTTON_HEIGHT: cfg_q.button_height <= cfg_data[9:0];
				REG_COOLDOWN_MS:   cfg_q.cooldown_ms   <= cfg_data;
				REG_PRESSURE_MIN:  cfg_q.pressure_min  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	tpq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_push (mid_push),
		.mid_item (mid_in),
		.mid_full (mid_full)
	);

	tpq_queue #(
		.Width ($bits(mid_item_t)),
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.data_in  (mid_in),
		.full     (mid_full),
		.pop      (mid_pop),
		.data_out (mid_out),
		.empty    (mid_empty)
	);

	tpq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_out),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_toggle_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.toggle |-> result.pressed && result.button_hit)
		else $error("toggle without a pressed hit");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.pressed |-> result.raw_x == 12'd0 && result.raw_y == 12'd0 &&
			result.screen_x == 10'd0 && result.screen_y == 10'd0 && !result.button_hit)
		else $error("coordinates not cleared without a press");

	a_full_only_on_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> mid_full && !mid_push)
		else $error("front stalled while the queue had room");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for touch_press_qualifier: directed table and random sample sets checked against a predictor.
module tb;
	import tpq_pkg::*;

	localparam int FullScale     = 4095;
	localparam int Phases        = 10;
	localparam int ItemsPerPhase = 140;
	localparam int DrainCycles   = 12;
	localparam int CycleLimit    = 1000000;

	typedef struct {
		in_item_t  stim;
		bit        pinned;
		out_item_t known;
	} test_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// expectation typed into the table travels alongside the item
	logic        item_pinned = 1'b0;
	out_item_t   item_known = '0;

	// predictor copy of the registers and the press/toggle state
	cfg_t shadow_cfg = '{11'd480, 11'd320, 11'sd194, 11'sd18, 10'd136, 10'd28, 16'd600, 13'd150};
	bit          pen_held = 1'b0;
	logic [31:0] last_toggle_ms = '0;

	out_item_t pending_results[$];
	int        errors = 0;
	int        cycle_count = 0;
	bit        calm = 1'b0;
	int        sink_wait = 0;

	// random gesture state
	logic [31:0] stamp_ms = '0;
	logic [31:0] anchor_ms = '0;
	int          hold_left = 0;
	int          lift_left = 0;
	int          aim_x = 0;
	int          aim_y = 0;

	touch_press_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int median3(int a, int b, int c);
		if ((a <= b && b <= c) || (c <= b && b <= a))
			return b;
		if ((b <= a && a <= c) || (c <= a && a <= b))
			return a;
		return c;
	endfunction

	function automatic int fit_size(logic [10:0] s);
		if (s == 0)
			return 1;
		if (s > SizeMax)
			return SizeMax;
		return s;
	endfunction

	function automatic int to_screen(int v, int size);
		if (v < int'(RawMin))
			v = RawMin;
		if (v > int'(RawMax))
			v = RawMax;
		return (v - int'(RawMin)) * (size - 1) / (int'(RawMax) - int'(RawMin));
	endfunction

	function automatic bit on_button(int x, int y);
		int l, t;
		l = $signed(shadow_cfg.button_left);
		t = $signed(shadow_cfg.button_top);
		return x >= l && x < l + int'(shadow_cfg.button_width) &&
			y >= t && y < t + int'(shadow_cfg.button_height);
	endfunction

	function automatic out_item_t qualify_touch(in_item_t s);
		out_item_t r;
		int w, h, sx, sy;
		bit hit;
		r = '0;
		r.pressed = s.pen_down && (int'(s.pressure_one) + FullScale - int'(s.pressure_two)
			>= int'(shadow_cfg.pressure_min));
		if (r.pressed) begin
			w = fit_size(shadow_cfg.screen_width);
			h = fit_size(shadow_cfg.screen_height);
			r.raw_x = 12'(median3(s.x_first, s.x_second, s.x_third));
			r.raw_y = 12'(median3(s.y_first, s.y_second, s.y_third));
			sx = to_screen(r.raw_x, w);
			sy = to_screen(r.raw_y, h);
			r.screen_x = 10'(sx);
			r.screen_y = 10'(sy);
			// the point is tried in all four screen orientations
			hit = on_button(sx, sy) || on_button(w - 1 - sy, sx) ||
				on_button(w - 1 - sx, h - 1 - sy) || on_button(sy, h - 1 - sx);
			r.button_hit = hit;
			if (!pen_held && (s.now_ms - last_toggle_ms) > 32'(shadow_cfg.cooldown_ms) && hit) begin
				r.toggle = 1'b1;
				last_toggle_ms = s.now_ms;
			end
		end
		pen_held = r.pressed;
		return r;
	endfunction

	task automatic report(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		out_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$error("result with no item waiting: %p", result);
					errors++;
				end else begin
					want = pending_results.pop_front();
					report("pressed", want.pressed, result.pressed);
					report("raw_x", want.raw_x, result.raw_x);
					report("raw_y", want.raw_y, result.raw_y);
					report("screen_x", want.screen_x, result.screen_x);
					report("screen_y", want.screen_y, result.screen_y);
					report("button_hit", want.button_hit, result.button_hit);
					report("toggle", want.toggle, result.toggle);
				end
			end
			if (push && !full) begin
				want = qualify_touch(item);
				if (item_pinned)
					want = item_known;
				pending_results.push_back(want);
			end
		end
	end

	function automatic int pick_gap();
		int r = $urandom_range(0, 15);
		if (r < 9)
			return 0;
		if (r < 15)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (sink_wait > 0) begin
			pop <= 1'b0;
			sink_wait <= sink_wait - 1;
		end else begin
			pop <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				sink_wait <= pick_gap();
		end
	end

	function automatic in_item_t noise();
		return in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
	endfunction

	function automatic in_item_t lifted();
		in_item_t s = noise();
		s.pen_down = 1'b0;
		return s;
	endfunction

	function automatic in_item_t touch_set(bit pen, int z1, int z2, int x1, int x2, int x3,
		int y1, int y2, int y3, logic [31:0] now);
		in_item_t s;
		s.pen_down     = pen;
		s.pressure_one = 12'(z1);
		s.pressure_two = 12'(z2);
		s.x_first      = 12'(x1);
		s.x_second     = 12'(x2);
		s.x_third      = 12'(x3);
		s.y_first      = 12'(y1);
		s.y_second     = 12'(y2);
		s.y_third      = 12'(y3);
		s.now_ms       = now;
		return s;
	endfunction

	// raw reading that lands inside the button span along one axis, or anywhere
	function automatic int aim_axis(int lo, int span, int size);
		int target;
		if ($urandom_range(0, 1) == 0 || size < 2)
			return $urandom_range(0, 4095);
		target = lo + $urandom_range(0, span);
		if (target < 0)
			target = 0;
		if (target > size - 1)
			target = size - 1;
		return int'(RawMin) + (target * (int'(RawMax) - int'(RawMin)) + size - 2) / (size - 1);
	endfunction

	function automatic logic [11:0] jitter(int centre);
		int v;
		if ($urandom_range(0, 5) == 0)
			return 12'($urandom);
		v = centre + $urandom_range(0, 40) - 20;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	// presses held for a few items, then lifts; now and then pure noise
	function automatic in_item_t next_sample();
		in_item_t s;
		int t;
		s = noise();
		if ($urandom_range(0, 15) == 0)
			return s;
		if (hold_left == 0 && lift_left > 0) begin
			lift_left--;
			stamp_ms += $urandom_range(0, 50);
			s.pen_down = 1'b0;
			s.now_ms = stamp_ms;
			return s;
		end
		if (hold_left == 0) begin
			hold_left = $urandom_range(1, 6);
			lift_left = $urandom_range(1, 3);
			aim_x = aim_axis($signed(shadow_cfg.button_left), shadow_cfg.button_width,
				fit_size(shadow_cfg.screen_width));
			aim_y = aim_axis($signed(shadow_cfg.button_top), shadow_cfg.button_height,
				fit_size(shadow_cfg.screen_height));
			case ($urandom_range(0, 3))
				0: stamp_ms = anchor_ms + shadow_cfg.cooldown_ms + $urandom_range(0, 2) - 1;
				1: stamp_ms = $urandom;
				default: stamp_ms += $urandom_range(0, 2 * shadow_cfg.cooldown_ms + 20);
			endcase
			anchor_ms = stamp_ms;
		end else begin
			stamp_ms += $urandom_range(0, 40);
		end
		hold_left--;
		s.pen_down = 1'b1;
		s.now_ms = stamp_ms;
		if ($urandom_range(0, 7) == 0) begin
			// right at the pressure threshold
			t = int'(shadow_cfg.pressure_min) + $urandom_range(0, 2) - 1;
			if (t < 0)
				t = 0;
			if (t > 2 * FullScale)
				t = 2 * FullScale;
			if (t <= FullScale) begin
				s.pressure_one = 12'(t);
				s.pressure_two = 12'(FullScale);
			end else begin
				s.pressure_one = 12'(FullScale);
				s.pressure_two = 12'(2 * FullScale - t);
			end
		end else begin
			s.pressure_two = 12'($urandom_range(0, 2047));
		end
		s.x_first  = jitter(aim_x);
		s.x_second = jitter(aim_x);
		s.x_third  = jitter(aim_x);
		s.y_first  = jitter(aim_y);
		s.y_second = jitter(aim_y);
		s.y_third  = jitter(aim_y);
		return s;
	endfunction

	function automatic logic [10:0] pick_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 11'($urandom_range(1025, 2047));
			2: return SizeMax;
			default: return 11'($urandom_range(2, 800));
		endcase
	endfunction

	task automatic send_item(in_item_t s, bit pin, out_item_t known, int gap);
		push <= 1'b1;
		item <= s;
		item_pinned <= pin;
		item_known <= known;
		do @(posedge clk); while (full);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SCREEN_WIDTH:  shadow_cfg.screen_width = data[10:0];
			REG_SCREEN_HEIGHT: shadow_cfg.screen_height = data[10:0];
			REG_BUTTON_LEFT:   shadow_cfg.button_left = data[10:0];
			REG_BUTTON_TOP:    shadow_cfg.button_top = data[10:0];
			REG_BUTTON_WIDTH:  shadow_cfg.button_width = data[9:0];
			REG_BUTTON_HEIGHT: shadow_cfg.button_height = data[9:0];
			REG_COOLDOWN_MS:   shadow_cfg.cooldown_ms = data;
			REG_PRESSURE_MIN:  shadow_cfg.pressure_min = data[12:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int phase);
		logic [15:0] v [8];
		logic [10:0] sw, sh;
		int left, top;
		case (phase)
			0: v = '{16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
			1: v = '{16'hFFFF, 16'h0400, 16'hFBFF, 16'hFBFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			// one-pixel screen and button: every press hits
			2: v = '{16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001,
				16'($urandom_range(0, 200)), 16'h0000};
			default: begin
				sw = pick_size();
				sh = pick_size();
				left = $urandom_range(0, fit_size(sw)) - 60;
				top = $urandom_range(0, fit_size(sh)) - 60;
				if ($urandom_range(0, 7) == 0)
					left = $urandom;
				v[REG_SCREEN_WIDTH]  = {5'($urandom), sw};
				v[REG_SCREEN_HEIGHT] = {5'($urandom), sh};
				v[REG_BUTTON_LEFT]   = {5'($urandom), 11'(left)};
				v[REG_BUTTON_TOP]    = {5'($urandom), 11'(top)};
				v[REG_BUTTON_WIDTH]  = {6'($urandom), ($urandom_range(0, 7) == 0) ?
					10'($urandom) : 10'($urandom_range(0, 250))};
				v[REG_BUTTON_HEIGHT] = {6'($urandom), 10'($urandom_range(0, 250))};
				case ($urandom_range(0, 5))
					0: v[REG_COOLDOWN_MS] = '0;
					1: v[REG_COOLDOWN_MS] = '1;
					default: v[REG_COOLDOWN_MS] = 16'($urandom_range(0, 2000));
				endcase
				v[REG_PRESSURE_MIN] = {3'($urandom), ($urandom_range(0, 7) == 0) ?
					13'($urandom) : 13'($urandom_range(0, 3000))};
			end
		endcase
		for (int i = REG_SCREEN_WIDTH; i <= REG_PRESSURE_MIN; i++)
			write_reg(4'(i), v[i]);
		// index past the register map: must be ignored
		write_reg(4'($urandom_range(REG_PRESSURE_MIN + 1, 15)), 16'($urandom));
	endtask

	// waits past the edge so the last accepted item is already queued for checking, then until all are checked
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin : stimulus
		test_row_t rows[$];
		bit quiet;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{touch_set(0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
			32'hFFFF_FFFF), 1'b1, '0});
		rows.push_back('{touch_set(1, 0, 4095, 9, 9, 9, 9, 9, 9, 0), 1'b1, '0});
		rows.push_back('{touch_set(1, 150, 4095, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			out_item_t'{pressed: 1'b1, default: '0}});
		rows.push_back('{touch_set(1, 149, 4095, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
		rows.push_back('{touch_set(1, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095, 0), 1'b1,
			out_item_t'{pressed: 1'b1, raw_x: 12'd4095, raw_y: 12'd4095, screen_x: 10'd479,
			screen_y: 10'd319, default: '0}});
		rows.push_back('{lifted(), 1'b1, '0});
		// press on the button, then held
		rows.push_back('{touch_set(1, 3000, 500, 4095, 2218, 0, 566, 100, 4000, 1000), 1'b0, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566, 5000), 1'b0, '0});
		// repress inside, at and just past the cooldown
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566, 1500), 1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566, 1600), 1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566, 1601), 1'b0, '0});
		// time counter wrapping
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566,
			32'hFFFF_FF00), 1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566,
			32'h0000_0100), 1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2218, 2218, 2218, 566, 566, 566,
			32'h0000_0200), 1'b0, '0});
		// hits in the other three orientations, with tied readings
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 450, 450, 4000, 2527, 0, 2527, 32'h1_0000),
			1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 1757, 1757, 1757, 3565, 4095, 3000,
			32'h2_0000), 1'b0, '0});
		rows.push_back('{lifted(), 1'b1, '0});
		rows.push_back('{touch_set(1, 3000, 500, 2448, 100, 2448, 3104, 3104, 0, 32'h3_0000),
			1'b0, '0});

		foreach (rows[i])
			send_item(rows[i].stim, rows[i].pinned, rows[i].known, pick_gap());

		for (int phase = 0; phase < Phases; phase++) begin
			settle();
			quiet = (phase % 3 == 1);
			calm <= quiet;
			configure(phase);
			hold_left = 0;
			repeat (ItemsPerPhase)
				send_item(next_sample(), 1'b0, '0, quiet ? 0 : pick_gap());
		end

		settle();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
